/* rtl/core/lcrd_pkg.sv */
// shared constants, types and control structs for the line-copy rle decoder
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package lcrd_pkg;

  localparam int MAX_LINE    = 1024;
  localparam int CHUNK_BYTES = 16;
  localparam int HIST_DEPTH  = 2 * MAX_LINE;
  localparam int HIST_AW     = $clog2(HIST_DEPTH);
  localparam int EMIT_W      = HIST_AW + 1;
  localparam int CNT_W       = 5;
  localparam int REM_W       = 10;
  localparam int CFG_W       = 11;
  localparam int CHUNK_W     = 8 * CHUNK_BYTES;

  localparam logic [7:0] ESC_CODE   = 8'hF8;
  localparam logic [7:0] PAIR_CODE  = 8'hFC;
  localparam logic [7:0] FILL_CODE  = 8'hFD;
  localparam logic [7:0] COPY2_CODE = 8'hFE;
  localparam logic [7:0] COPY1_CODE = 8'hFF;

  typedef enum logic [1:0] {
    RUN_FILL  = 2'd0,
    RUN_PAIR  = 2'd1,
    RUN_COPY2 = 2'd2,
    RUN_COPY1 = 2'd3
  } run_kind_e;

  typedef struct packed {
    logic      gen;
    logic      put_lit;
    logic      emit_empty;
    logic      bad;
    logic      cut;
    logic      last;
    logic      load_len;
    logic      load_first;
    logic      start_run;
    run_kind_e kind;
    logic      clear_hist;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic run_done;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/core/lcrd_ctrl.sv */
// token parser and run sequencer of the line-copy rle decoder
// depends on lcrd_pkg; drives commands into lcrd_datapath
`default_nettype none

module lcrd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    code_byte_i,
  input  wire logic          last_byte_i,
  input  wire lcrd_pkg::stat_t st_i,
  output lcrd_pkg::cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_GEN  = 2'b10
  } state_e;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_ESC    = 5'b00010,
    PH_COUNT  = 5'b00100,
    PH_FIRST  = 5'b01000,
    PH_SECOND = 5'b10000
  } phase_e;

  state_e      state_q, state_d;
  phase_e      ph_q, ph_d;
  logic [1:0]  pend_q, pend_d;
  logic        accept;

  assign accept     = in_valid_i && (state_q == ST_IDLE) && st_i.out_free;
  assign in_stall_o = !((state_q == ST_IDLE) && st_i.out_free);

  always_comb begin
    cmd_o         = '0;
    cmd_o.kind    = lcrd_pkg::RUN_FILL;
    state_d       = state_q;
    ph_d          = ph_q;
    pend_d        = pend_q;
    cmd_o.gen     = (state_q == ST_GEN);
    cmd_o.last    = last_byte_i;
    if (accept) begin
      unique case (ph_q)
        PH_IDLE: begin
          if (code_byte_i < lcrd_pkg::ESC_CODE) begin
            cmd_o.put_lit = 1'b1;
          end else if (code_byte_i == lcrd_pkg::ESC_CODE) begin
            ph_d = PH_ESC;
          end else if (code_byte_i >= lcrd_pkg::PAIR_CODE) begin
            pend_d = code_byte_i[1:0];
            ph_d   = PH_COUNT;
          end else begin
            cmd_o.bad        = 1'b1;
            cmd_o.emit_empty = 1'b1;
          end
        end
        PH_ESC: begin
          cmd_o.put_lit = 1'b1;
          ph_d          = PH_IDLE;
        end
        PH_COUNT: begin
          cmd_o.load_len = 1'b1;
          if (pend_q == lcrd_pkg::COPY2_CODE[1:0]) begin
            cmd_o.start_run = 1'b1;
            cmd_o.kind      = lcrd_pkg::RUN_COPY2;
            ph_d            = PH_IDLE;
          end else if (pend_q == lcrd_pkg::COPY1_CODE[1:0]) begin
            cmd_o.start_run = 1'b1;
            cmd_o.kind      = lcrd_pkg::RUN_COPY1;
            ph_d            = PH_IDLE;
          end else begin
            ph_d = PH_FIRST;
          end
        end
        PH_FIRST: begin
          if (pend_q == lcrd_pkg::FILL_CODE[1:0]) begin
            cmd_o.start_run = 1'b1;
            cmd_o.kind      = lcrd_pkg::RUN_FILL;
            ph_d            = PH_IDLE;
          end else begin
            cmd_o.load_first = 1'b1;
            ph_d             = PH_SECOND;
          end
        end
        PH_SECOND: begin
          cmd_o.start_run = 1'b1;
          cmd_o.kind      = lcrd_pkg::RUN_PAIR;
          ph_d            = PH_IDLE;
        end
        default: begin
          ph_d = PH_IDLE;
        end
      endcase
      if (cmd_o.start_run) begin
        state_d = ST_GEN;
      end
      if (last_byte_i) begin
        // end of image: dropped token is flagged, parser restarts
        if (!cmd_o.start_run) begin
          if (!cmd_o.put_lit && !cmd_o.emit_empty) begin
            cmd_o.emit_empty = 1'b1;
            cmd_o.cut        = (ph_d != PH_IDLE);
          end
          cmd_o.clear_hist = 1'b1;
        end
        ph_d   = PH_IDLE;
        pend_d = 2'd0;
      end
    end
    if ((state_q == ST_GEN) && st_i.run_done) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q    <= PH_IDLE;
      pend_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      pend_q  <= pend_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lcrd_datapath.sv */
// history memory, chunk assembly and output register of the decoder
// depends on lcrd_pkg; commanded by lcrd_ctrl
`default_nettype none

module lcrd_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  input  wire logic [lcrd_pkg::CFG_W-1:0]  line_width_i,
  input  wire logic [7:0]                  code_byte_i,
  input  wire lcrd_pkg::cmd_t              cmd_i,
  output lcrd_pkg::stat_t                  st_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [lcrd_pkg::CHUNK_W-1:0]     out_data_o,
  output logic [lcrd_pkg::CNT_W-1:0]       out_count_o,
  output logic                             out_run_done_o,
  output logic                             out_bad_o,
  output logic                             out_cut_o,
  output logic                             out_image_done_o
);

  logic [7:0]                     mem [lcrd_pkg::HIST_DEPTH];
  logic [7:0]                     mem_q;
  logic                           zero_q;
  logic [lcrd_pkg::HIST_AW-1:0]   ptr_q, ptr_d, rd_addr;
  logic [lcrd_pkg::EMIT_W-1:0]    emit_q, emit_d;
  logic [lcrd_pkg::CFG_W-1:0]     lw_q;
  logic [lcrd_pkg::EMIT_W-1:0]    w_eff, dist_q, dist_d;
  logic [7:0]                     len_q, len_d, first_q, first_d;
  logic [7:0]                     va_q, va_d, vb_q, vb_d;
  lcrd_pkg::run_kind_e            kind_q, kind_d;
  logic                           last_q, last_d, selb_q, selb_d, rdp_q, rdp_d;
  logic [lcrd_pkg::REM_W-1:0]     rem_q, rem_d;
  logic [lcrd_pkg::CHUNK_W-1:0]   acc_q, acc_d;
  logic [lcrd_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                           wr_en;
  logic [7:0]                     wr_data;
  logic                           out_load, out_valid_d;
  logic [lcrd_pkg::CHUNK_W-1:0]   od_d;
  logic [lcrd_pkg::CNT_W-1:0]     oc_d;
  logic                           orun_d, obad_d, ocut_d, oimg_d;
  logic                           acc_full, is_copy;
  logic [7:0]                     gen_byte;
  logic                           out_free, run_end;

  always_comb begin
    if (lw_q == '0) begin
      w_eff = lcrd_pkg::EMIT_W'(1);
    end else if (32'(lw_q) > lcrd_pkg::MAX_LINE) begin
      w_eff = lcrd_pkg::EMIT_W'(lcrd_pkg::MAX_LINE);
    end else begin
      w_eff = lcrd_pkg::EMIT_W'(lw_q);
    end
  end

  assign out_free      = !out_valid_o || !out_stall_i;
  assign st_o          = '{out_free: out_free, run_done: run_end};
  assign rd_addr       = ptr_q - dist_q[lcrd_pkg::HIST_AW-1:0];
  assign acc_full      = (cnt_q == lcrd_pkg::CNT_W'(lcrd_pkg::CHUNK_BYTES));
  assign is_copy       = (kind_q == lcrd_pkg::RUN_COPY1) || (kind_q == lcrd_pkg::RUN_COPY2);

  always_comb begin
    if (is_copy) begin
      gen_byte = zero_q ? 8'd0 : mem_q;
    end else if ((kind_q == lcrd_pkg::RUN_PAIR) && selb_q) begin
      gen_byte = vb_q;
    end else begin
      gen_byte = va_q;
    end
  end

  always_comb begin
    ptr_d   = ptr_q;
    emit_d  = emit_q;
    dist_d  = dist_q;
    len_d   = len_q;
    first_d = first_q;
    va_d    = va_q;
    vb_d    = vb_q;
    kind_d  = kind_q;
    last_d  = last_q;
    selb_d  = selb_q;
    rdp_d   = rdp_q;
    rem_d   = rem_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    wr_en   = 1'b0;
    wr_data = code_byte_i;
    out_load = 1'b0;
    od_d    = '0;
    oc_d    = '0;
    orun_d  = 1'b0;
    obad_d  = 1'b0;
    ocut_d  = 1'b0;
    oimg_d  = 1'b0;
    run_end = 1'b0;

    if (cmd_i.load_len) begin
      len_d = code_byte_i;
    end
    if (cmd_i.load_first) begin
      first_d = code_byte_i;
    end
    if (cmd_i.start_run) begin
      kind_d = cmd_i.kind;
      last_d = cmd_i.last;
      selb_d = 1'b0;
      rdp_d  = 1'b0;
      acc_d  = '0;
      vb_d   = code_byte_i;
      va_d   = (cmd_i.kind == lcrd_pkg::RUN_PAIR) ? first_q : code_byte_i;
      dist_d = (cmd_i.kind == lcrd_pkg::RUN_COPY2) ? (w_eff << 1) : w_eff;
      unique case (cmd_i.kind)
        lcrd_pkg::RUN_FILL:  rem_d = lcrd_pkg::REM_W'(len_q) + lcrd_pkg::REM_W'(4);
        lcrd_pkg::RUN_PAIR:  rem_d = (lcrd_pkg::REM_W'(len_q) + lcrd_pkg::REM_W'(3)) << 1;
        default:             rem_d = lcrd_pkg::REM_W'(code_byte_i) + lcrd_pkg::REM_W'(3);
      endcase
    end

    // single-result bytes go straight to the output register
    if (cmd_i.put_lit || cmd_i.emit_empty) begin
      out_load = 1'b1;
      orun_d   = 1'b1;
      obad_d   = cmd_i.bad;
      ocut_d   = cmd_i.cut;
      oimg_d   = cmd_i.last;
      if (cmd_i.put_lit) begin
        wr_en   = 1'b1;
        wr_data = code_byte_i;
        od_d    = lcrd_pkg::CHUNK_W'(code_byte_i);
        oc_d    = lcrd_pkg::CNT_W'(1);
      end
    end

    if (cmd_i.gen) begin
      if (rem_q == '0) begin
        if (out_free) begin
          out_load      = 1'b1;
          od_d          = acc_q;
          oc_d          = cnt_q;
          orun_d        = 1'b1;
          oimg_d        = last_q;
          acc_d         = '0;
          cnt_d         = '0;
          run_end       = 1'b1;
        end
      end else if (acc_full) begin
        if (out_free) begin
          out_load = 1'b1;
          od_d     = acc_q;
          oc_d     = cnt_q;
          acc_d    = '0;
          cnt_d    = '0;
        end
      end else if (is_copy && !rdp_q) begin
        // history read issued this cycle, data lands next cycle
        rdp_d = 1'b1;
      end else begin
        rdp_d   = 1'b0;
        wr_en   = 1'b1;
        wr_data = gen_byte;
        selb_d  = !selb_q;
        rem_d   = rem_q - lcrd_pkg::REM_W'(1);
        cnt_d   = cnt_q + lcrd_pkg::CNT_W'(1);
        for (int k = 0; k < lcrd_pkg::CHUNK_BYTES; k++) begin
          if (cnt_q == lcrd_pkg::CNT_W'(k)) begin
            acc_d[8*k +: 8] = gen_byte;
          end
        end
      end
    end

    if (wr_en) begin
      ptr_d = ptr_q + lcrd_pkg::HIST_AW'(1);
      if (emit_q != lcrd_pkg::EMIT_W'(lcrd_pkg::HIST_DEPTH)) begin
        emit_d = emit_q + lcrd_pkg::EMIT_W'(1);
      end
    end
    if (cmd_i.clear_hist || (run_end && last_q)) begin
      ptr_d  = '0;
      emit_d = '0;
    end

    out_valid_d = out_load || (out_valid_o && out_stall_i);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[ptr_q] <= wr_data;
    end
    mem_q  <= mem[rd_addr];
    zero_q <= (dist_q > emit_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      emit_q      <= '0;
      lw_q        <= lcrd_pkg::CFG_W'(1);
      rem_q       <= '0;
      cnt_q       <= '0;
      rdp_q       <= 1'b0;
      selb_q      <= 1'b0;
      last_q      <= 1'b0;
      kind_q      <= lcrd_pkg::RUN_FILL;
      out_valid_o <= 1'b0;
    end else begin
      ptr_q       <= ptr_d;
      emit_q      <= emit_d;
      rem_q       <= rem_d;
      cnt_q       <= cnt_d;
      rdp_q       <= rdp_d;
      selb_q      <= selb_d;
      last_q      <= last_d;
      kind_q      <= kind_d;
      out_valid_o <= out_valid_d;
      if (cfg_valid_i) begin
        lw_q <= line_width_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q  <= dist_d;
    len_q   <= len_d;
    first_q <= first_d;
    va_q    <= va_d;
    vb_q    <= vb_d;
    acc_q   <= acc_d;
    if (out_load) begin
      out_data_o       <= od_d;
      out_count_o      <= oc_d;
      out_run_done_o   <= orun_d;
      out_bad_o        <= obad_d;
      out_cut_o        <= ocut_d;
      out_image_done_o <= oimg_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/line_copy_rle_decoder_unit.sv */
// output: a literal or escaped byte shows its word in the cycle after acceptance
// throughput: literal, escape and prefix bytes are taken one per cycle while the output
//   is free; fill and pair runs decode one byte per cycle, pausing while each 16-byte
//   word is handed out; line copies wait for a registered history read before each byte
// reset: asynchronous active low, parser idle, history empty, line width 1
// top level: lcrd_ctrl (parser, sequencer) and lcrd_datapath (history, words)
`default_nettype none

module line_copy_rle_decoder_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write, always ready
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [lcrd_pkg::CFG_W-1:0]  line_width_i,
  // compressed input bytes
  input  wire logic                        valid_i,
  output logic                             stall_o,
  input  wire logic [7:0]                  code_byte_i,
  input  wire logic                        last_byte_i,
  // decoded output words
  output logic                             valid_o,
  input  wire logic                        stall_i,
  output logic [63:0]                      data_low_o,
  output logic [63:0]                      data_high_o,
  output logic [4:0]                       byte_count_o,
  output logic                             run_done_o,
  output logic                             bad_code_o,
  output logic                             cut_token_o,
  output logic                             image_done_o
);

  lcrd_pkg::cmd_t                 cmd;
  lcrd_pkg::stat_t                st;
  logic [lcrd_pkg::CHUNK_W-1:0]   out_data;

  // line width register accepts a write every cycle
  assign cfg_ready_o = 1'b1;

  lcrd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_i),
    .in_stall_o  (stall_o),
    .code_byte_i (code_byte_i),
    .last_byte_i (last_byte_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  lcrd_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .line_width_i     (line_width_i),
    .code_byte_i      (code_byte_i),
    .cmd_i            (cmd),
    .st_o             (st),
    .out_valid_o      (valid_o),
    .out_stall_i      (stall_i),
    .out_data_o       (out_data),
    .out_count_o      (byte_count_o),
    .out_run_done_o   (run_done_o),
    .out_bad_o        (bad_code_o),
    .out_cut_o        (cut_token_o),
    .out_image_done_o (image_done_o)
  );

  // word byte 0 sits in the low bits
  assign data_low_o  = out_data[63:0];
  assign data_high_o = out_data[127:64];

`ifndef ASSERT_OFF
  // words ahead of the last one of a run are always full
  a_mid_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !run_done_o) |-> (byte_count_o == 5'd16))
    else $error("partial word before end of run");

  a_img_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && image_done_o) |-> run_done_o)
    else $error("image end not on final word");

  // a cut token never carries decoded bytes
  a_cut_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && cut_token_o) |-> (image_done_o && (byte_count_o == 5'd0)))
    else $error("cut token flag on a word with data");

  // while a run is expanding no new input is taken
  a_gen_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.gen |-> stall_o)
    else $error("input taken during run expansion");
`endif

endmodule

`default_nettype wire

/* verif/tb_line_copy_rle_decoder_unit.sv */
// self-checking bench for line_copy_rle_decoder_unit: directed table, then random tokens
// depends on lcrd_pkg and the decoder rtl; predicts every output word in the bench
`default_nettype none

module tb_line_copy_rle_decoder_unit;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  cnt;
    logic        run_done;
    logic        bad;
    logic        cut;
    logic        img_done;
  } word_t;

  typedef struct {
    logic [7:0] code;
    logic       last;
    bit         typed;   // expected word written in the table
    word_t      want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [lcrd_pkg::CFG_W-1:0] line_width_i = '0;
  logic valid_i = 1'b0;
  logic stall_o;
  logic [7:0] code_byte_i = '0;
  logic last_byte_i = 1'b0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic [63:0] data_low_o, data_high_o;
  logic [4:0] byte_count_o;
  logic run_done_o, bad_code_o, cut_token_o, image_done_o;

  line_copy_rle_decoder_unit dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .line_width_i,
    .valid_i, .stall_o, .code_byte_i, .last_byte_i,
    .valid_o, .stall_i, .data_low_o, .data_high_o, .byte_count_o,
    .run_done_o, .bad_code_o, .cut_token_o, .image_done_o
  );

  // predictor state
  typedef enum int {P_IDLE, P_ESC, P_COUNT, P_FIRST, P_SECOND} phase_e;
  phase_e              phase;
  lcrd_pkg::run_kind_e kind;
  logic [7:0]  run_len, pair_a;
  logic [7:0]  hist [lcrd_pkg::HIST_DEPTH];
  int          hptr, emitted;
  logic [lcrd_pkg::CFG_W-1:0] width_reg;

  word_t pending_words[$];
  word_t cur;
  int    produced;
  bit    failed = 1'b0;
  bit    hold_off = 1'b0;
  bit    quiet = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void close_word();
    pending_words.push_back(cur);
    produced++;
    cur = '0;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    hist[hptr] = b;
    hptr = (hptr + 1) % lcrd_pkg::HIST_DEPTH;
    if (emitted < lcrd_pkg::HIST_DEPTH) emitted++;
    if (cur.cnt < 8) cur.lo[8*cur.cnt +: 8] = b;
    else cur.hi[8*(cur.cnt-8) +: 8] = b;
    cur.cnt++;
    if (cur.cnt == lcrd_pkg::CHUNK_BYTES) close_word();
  endfunction

  function automatic logic [7:0] hist_back(int span);
    if (span == 0 || span > emitted) return 8'h00;
    return hist[(hptr + lcrd_pkg::HIST_DEPTH - span) % lcrd_pkg::HIST_DEPTH];
  endfunction

  // expected words of one accepted code byte
  function automatic void decode_byte(logic [7:0] c, logic last);
    bit bad;
    int n, span;
    bad = 0;
    produced = 0;
    cur = '0;
    case (phase)
      P_IDLE: begin
        if (c < lcrd_pkg::ESC_CODE) put_byte(c);
        else if (c == lcrd_pkg::ESC_CODE) phase = P_ESC;
        else if (c >= lcrd_pkg::PAIR_CODE) begin
          kind = lcrd_pkg::run_kind_e'(c[1:0]);
          phase = P_COUNT;
        end else bad = 1;
      end
      P_ESC: begin
        put_byte(c);
        phase = P_IDLE;
      end
      P_COUNT: begin
        run_len = c;
        if (kind == lcrd_pkg::RUN_COPY2 || kind == lcrd_pkg::RUN_COPY1) begin
          span = (width_reg == 0) ? 1 :
                 (width_reg > lcrd_pkg::MAX_LINE ? lcrd_pkg::MAX_LINE : int'(width_reg));
          if (kind == lcrd_pkg::RUN_COPY2) span *= 2;
          n = run_len + 3;
          for (int i = 0; i < n; i++) put_byte(hist_back(span));
          phase = P_IDLE;
        end else phase = P_FIRST;
      end
      P_FIRST: begin
        if (kind == lcrd_pkg::RUN_PAIR) begin
          n = run_len + 4;
          for (int i = 0; i < n; i++) put_byte(c);
          phase = P_IDLE;
        end else begin
          pair_a = c;
          phase = P_SECOND;
        end
      end
      default: begin
        n = run_len + 3;
        for (int i = 0; i < n; i++) begin
          put_byte(pair_a);
          put_byte(c);
        end
        phase = P_IDLE;
      end
    endcase
    if (cur.cnt > 0 || (produced == 0 && (last || bad))) close_word();
    if (produced > 0) begin
      pending_words[$].run_done = 1'b1;
      pending_words[$].bad = bad;
      pending_words[$].cut = last && phase != P_IDLE;
      pending_words[$].img_done = last;
    end
    if (last) begin
      phase = P_IDLE;
      hptr = 0;
      emitted = 0;
    end
  endfunction

  // output side: stall at random, and one long hold-off on request
  initial begin
    int stretch;
    stretch = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        stall_i <= 1'b1;
        if (++stretch > 300) hold_off = 1'b0;
      end else begin
        stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 19);
      end
    end
  end

  // compare every accepted output word with the oldest expectation
  always @(posedge clk_i) begin
    word_t w;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word lo=%h cnt=%0d", data_low_o, byte_count_o);
        failed = 1'b1;
      end else begin
        w = pending_words.pop_front();
        if (data_low_o !== w.lo) begin
          $error("data_low exp %h got %h", w.lo, data_low_o); failed = 1'b1;
        end
        if (data_high_o !== w.hi) begin
          $error("data_high exp %h got %h", w.hi, data_high_o); failed = 1'b1;
        end
        if (byte_count_o !== w.cnt) begin
          $error("byte_count exp %0d got %0d", w.cnt, byte_count_o); failed = 1'b1;
        end
        if (run_done_o !== w.run_done) begin
          $error("run_done exp %b got %b", w.run_done, run_done_o); failed = 1'b1;
        end
        if (bad_code_o !== w.bad) begin
          $error("bad_code exp %b got %b", w.bad, bad_code_o); failed = 1'b1;
        end
        if (cut_token_o !== w.cut) begin
          $error("cut_token exp %b got %b", w.cut, cut_token_o); failed = 1'b1;
        end
        if (image_done_o !== w.img_done) begin
          $error("image_done exp %b got %b", w.img_done, image_done_o); failed = 1'b1;
        end
      end
    end
  end

  // one code byte into the decoder, with random gaps; prediction at acceptance
  task automatic send_byte(logic [7:0] c, logic l);
    while (!quiet && $urandom_range(99) < 19) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i <= 1'b1;
    code_byte_i <= c;
    last_byte_i <= l;
    do @(posedge clk_i); while (stall_o);
    decode_byte(c, l);
    @(negedge clk_i);
  endtask

  task automatic drain_then_idle();
    valid_i <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_width(logic [lcrd_pkg::CFG_W-1:0] w);
    cfg_valid_i <= 1'b1;
    line_width_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    width_reg = w;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random but mostly well-formed token with random contents
  task automatic send_token(bit l);
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) send_byte(8'($urandom_range(8'hF7)), l);
    else if (pick < 52) begin
      send_byte(lcrd_pkg::ESC_CODE, 1'b0); send_byte(8'($urandom_range(255)), l);
    end else if (pick < 60) begin
      send_byte(lcrd_pkg::FILL_CODE, 1'b0);
      send_byte(8'($urandom_range(3) == 0 ? 8'hFF : $urandom_range(20)), 1'b0);
      send_byte(8'($urandom_range(255)), l);
    end else if (pick < 68) begin
      send_byte(lcrd_pkg::PAIR_CODE, 1'b0);
      send_byte(8'($urandom_range(3) == 0 ? 8'hFF : $urandom_range(12)), 1'b0);
      send_byte(8'($urandom_range(255)), 1'b0); send_byte(8'($urandom_range(255)), l);
    end else if (pick < 88) begin
      send_byte($urandom_range(1) ? lcrd_pkg::COPY1_CODE : lcrd_pkg::COPY2_CODE, 1'b0);
      send_byte(8'($urandom_range(7) == 0 ? 8'hFF : $urandom_range(20)), l);
    end else if (pick < 94) send_byte(8'($urandom_range(8'hF9, 8'hFB)), l);
    else send_byte(8'($urandom_range(8'hFC, 8'hFF)), l);   // possibly cut token
  endtask

  row_t dir_rows[$];

  function automatic row_t row(logic [7:0] c, logic l, bit t = 0, word_t w = '0);
    row_t r;
    r.code = c; r.last = l; r.typed = t; r.want = w;
    return r;
  endfunction

  initial begin
    logic [lcrd_pkg::CFG_W-1:0] widths[6];
    widths = '{11'd0, 11'd2047, 11'd1024, 11'd3, 11'd17, 11'd5};
    width_reg = lcrd_pkg::CFG_W'(1);
    phase = P_IDLE; hptr = 0; emitted = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // literal extremes, escape, every run kind, undefined codes, cut token
    dir_rows.push_back(row(8'h00, 1'b0, 1,
      '{64'h0, 64'h0, 5'd1, 1'b1, 1'b0, 1'b0, 1'b0}));
    dir_rows.push_back(row(8'hF7, 1'b0, 1,
      '{64'hF7, 64'h0, 5'd1, 1'b1, 1'b0, 1'b0, 1'b0}));
    dir_rows.push_back(row(lcrd_pkg::ESC_CODE, 1'b0));
    dir_rows.push_back(row(8'hFF, 1'b0, 1,
      '{64'hFF, 64'h0, 5'd1, 1'b1, 1'b0, 1'b0, 1'b0}));
    dir_rows.push_back(row(8'hF9, 1'b0, 1,
      '{64'h0, 64'h0, 5'd0, 1'b1, 1'b1, 1'b0, 1'b0}));
    dir_rows.push_back(row(8'hFA, 1'b0));
    dir_rows.push_back(row(8'hFB, 1'b0));
    dir_rows.push_back(row(lcrd_pkg::FILL_CODE, 1'b0));
    dir_rows.push_back(row(8'd0, 1'b0));
    dir_rows.push_back(row(8'hAA, 1'b0));
    dir_rows.push_back(row(lcrd_pkg::PAIR_CODE, 1'b0));
    dir_rows.push_back(row(8'd2, 1'b0));
    dir_rows.push_back(row(8'h12, 1'b0));
    dir_rows.push_back(row(8'h34, 1'b0));
    dir_rows.push_back(row(lcrd_pkg::COPY1_CODE, 1'b0));
    dir_rows.push_back(row(8'd5, 1'b0));
    dir_rows.push_back(row(lcrd_pkg::COPY2_CODE, 1'b0));
    dir_rows.push_back(row(8'hFF, 1'b0));
    dir_rows.push_back(row(lcrd_pkg::FILL_CODE, 1'b0));
    dir_rows.push_back(row(8'hFF, 1'b0));
    dir_rows.push_back(row(8'h5A, 1'b0));
    dir_rows.push_back(row(lcrd_pkg::COPY1_CODE, 1'b1, 1,
      '{64'h0, 64'h0, 5'd0, 1'b1, 1'b0, 1'b1, 1'b1}));
    // new image: copy reads before the start give zero
    dir_rows.push_back(row(lcrd_pkg::COPY2_CODE, 1'b0));
    dir_rows.push_back(row(8'd0, 1'b1, 1,
      '{64'h0, 64'h0, 5'd3, 1'b1, 1'b0, 1'b0, 1'b1}));

    foreach (dir_rows[i]) begin
      word_t typed;
      send_byte(dir_rows[i].code, dir_rows[i].last);
      if (dir_rows[i].typed) begin
        // the typed row must agree with the prediction it produced
        typed = pending_words[$];
        if (typed !== dir_rows[i].want) begin
          $error("table row %0d: typed %h predicted %h", i, dir_rows[i].want, typed);
          failed = 1'b1;
        end
      end
    end
    drain_then_idle();

    // random images over several widths, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      set_width(widths[ph]);
      quiet = (ph == 2);
      for (int k = 0; k < 28; k++) begin
        if (ph == 3 && k == 2) hold_off = 1'b1;   // receiver holds off, input stalls
        send_token(k == 27 || $urandom_range(15) == 0);
      end
      drain_then_idle();
    end
    quiet = 1'b0;

    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
